### rtl/core/rprs_pkg.sv
// ----------------------------------------------------------------------------
// Repeat packet ring scheduler package
// Shared constants, operation codes and the cell control type.
// ----------------------------------------------------------------------------
package rprs_pkg;

	localparam int DEPTH_DEF         = 16;
	localparam int PAYLOAD_BYTES_DEF = 6;
	localparam int PAY_PORT_W        = 48;
	localparam int ADDR_W            = 16;
	localparam int REP_W             = 8;
	localparam int BYTES_W           = 3;
	localparam int CAP_W             = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Request kinds on the input stream.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_NEXT   = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	// Per-cycle cell operations.
	localparam logic [2:0] OP_HOLD    = 3'd0;
	localparam logic [2:0] OP_INSERT  = 3'd1;
	localparam logic [2:0] OP_SCAN    = 3'd2;
	localparam logic [2:0] OP_COMPACT = 3'd3;
	localparam logic [2:0] OP_ROTATE  = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic       by_addr;
	} cell_ctl_t;

endpackage

### rtl/core/rprs_cell.sv
// ----------------------------------------------------------------------------
// Ring cell
// Holds one packet at one ring position and trades it with its neighbors.
// ----------------------------------------------------------------------------
module rprs_cell #(
	parameter int SW = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rprs_pkg::cell_ctl_t       ctl,
	input  logic [rprs_pkg::ADDR_W-1:0] key_addr,
	input  logic [SW+26:0]            left_d,
	input  logic                      left_v,
	input  logic                      left_l,
	input  logic [SW+26:0]            right_d,
	input  logic                      right_v,
	input  logic                      right_l,
	input  logic [SW+26:0]            head_d,
	input  logic                      tok_in,
	input  logic                      fnd_in,
	output logic [SW+26:0]            d,
	output logic                      v,
	output logic                      l,
	output logic                      tok,
	output logic                      fnd,
	output logic                      sh
);

	logic [SW+26:0] data_q;
	logic           valid_q;
	logic           last_q;
	logic           tok_q;
	logic           fnd_q;
	logic           sh_q;
	logic           crit;
	logic           hit;

	assign crit = ctl.by_addr ? (data_q[SW+26:SW+11] == key_addr)
	                          : (last_q && (data_q[SW+10:SW+3] == '0));
	assign hit  = tok_in && valid_q && crit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			tok_q   <= 1'b0;
			fnd_q   <= 1'b0;
			sh_q    <= 1'b0;
		end else begin
			unique case (ctl.op)
				rprs_pkg::OP_INSERT: begin
					valid_q <= left_v;
					last_q  <= left_l;
				end
				rprs_pkg::OP_SCAN: begin
					tok_q <= tok_in;
					fnd_q <= fnd_in || hit;
					if (tok_in && (fnd_in || hit))
						sh_q <= 1'b1;
				end
				rprs_pkg::OP_COMPACT: begin
					if (sh_q) begin
						valid_q <= right_v;
						last_q  <= right_l;
					end
					sh_q <= 1'b0;
				end
				rprs_pkg::OP_ROTATE: begin
					// The head moves to the end of the ring and becomes the last sent.
					if (valid_q)
						last_q <= !right_v;
				end
				rprs_pkg::OP_CLEAR: begin
					valid_q <= 1'b0;
					last_q  <= 1'b0;
					sh_q    <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			rprs_pkg::OP_INSERT:  data_q <= left_d;
			rprs_pkg::OP_COMPACT: if (sh_q) data_q <= right_d;
			rprs_pkg::OP_ROTATE:  if (valid_q) data_q <= right_v ? right_d : head_d;
			default: begin
			end
		endcase
	end

	assign d   = data_q;
	assign v   = valid_q;
	assign l   = last_q;
	assign tok = tok_q;
	assign fnd = fnd_q;
	assign sh  = sh_q;

endmodule

### rtl/core/repeat_packet_ring_scheduler.sv
// ----------------------------------------------------------------------------
// Repeat packet ring scheduler
// Round-robin queue of repeated packets held in a chain of ring cells.
// ----------------------------------------------------------------------------
// Packets sit in a row of DEPTH cells in ring order, the cell at the front
// being the read position. Insert and clear are done in the execute state.
// Next and remove run a search token down the cell chain, one cell per
// cycle, then close any gap; next then rotates the head to the end of the
// ring. One request is in work at a time and a new one is taken once the
// previous result has been transferred.
module repeat_packet_ring_scheduler #(
	parameter int DEPTH         = rprs_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BYTES = rprs_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // addr, repeat_count, byte_count, payload
	input  logic [1:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // ok, sent_addr, sent_count, sent_payload,
	                              // repeats_left, has_next
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SW    = (PAYLOAD_BYTES * 8 < rprs_pkg::PAY_PORT_W) ?
	                       PAYLOAD_BYTES * 8 : rprs_pkg::PAY_PORT_W;
	localparam int DW    = SW + 27;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int STP_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > rprs_pkg::CAP_W) ? CNT_W : rprs_pkg::CAP_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_EXEC    = 3'd1;
	localparam logic [2:0] ST_SCAN    = 3'd2;
	localparam logic [2:0] ST_COMPACT = 3'd3;
	localparam logic [2:0] ST_ROTATE  = 3'd4;

	logic [rprs_pkg::CAP_W-1:0] capacity_q;
	logic [2:0]                 state_q;
	logic [STP_W-1:0]           step_q;
	logic [CNT_W-1:0]           count_q;
	logic [1:0]                 kind_q;
	logic [rprs_pkg::ADDR_W-1:0] addr_q;
	logic [DW-1:0]              new_q;
	logic                       out_valid_q;
	logic [79:0]                out_q;

	// APB register
	assign pready = 1'b1;
	assign prdata = {{(32 - rprs_pkg::CAP_W){1'b0}}, capacity_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			capacity_q <= rprs_pkg::CAP_RESET;
		else if (psel && penable && pwrite && pready && !paddr[2])
			capacity_q <= pwdata[rprs_pkg::CAP_W-1:0];
	end

	// Incoming packet fields, saturated and trimmed to storage width.
	logic [3:0]                  bytes_ext;
	logic [rprs_pkg::BYTES_W-1:0] bytes_sat;
	assign bytes_ext = {1'b0, s_tdata[26:24]};
	assign bytes_sat = (bytes_ext > 4'(PAYLOAD_BYTES)) ?
	                   rprs_pkg::BYTES_W'(PAYLOAD_BYTES) : s_tdata[26:24];

	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;

	// Cell chain
	rprs_pkg::cell_ctl_t ctl;
	logic [DW-1:0] cd   [DEPTH];
	logic          cv   [DEPTH];
	logic          cl   [DEPTH];
	logic          ctok [DEPTH];
	logic          cfnd [DEPTH];
	logic          csh  [DEPTH];
	logic [DW-1:0] head_dec;
	logic [rprs_pkg::REP_W-1:0] head_rep;

	assign head_rep = cd[0][SW+10:SW+3];
	assign head_dec = {cd[0][SW+26:SW+11],
	                   (head_rep == '0) ? head_rep : head_rep - 8'd1,
	                   cd[0][SW+2:0]};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DW-1:0] ld, rd;
		logic          lv, ll, rv, rl, ti, fi;
		if (i == 0) begin : g_first
			assign ld = new_q;
			assign lv = 1'b1;
			assign ll = 1'b0;
			assign ti = (state_q == ST_EXEC);
			assign fi = 1'b0;
		end else begin : g_mid
			assign ld = cd[i-1];
			assign lv = cv[i-1];
			assign ll = cl[i-1];
			assign ti = ctok[i-1];
			assign fi = cfnd[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign rd = '0;
			assign rv = 1'b0;
			assign rl = 1'b0;
		end else begin : g_inner
			assign rd = cd[i+1];
			assign rv = cv[i+1];
			assign rl = cl[i+1];
		end
		rprs_cell #(.SW(SW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key_addr (addr_q),
			.left_d   (ld),
			.left_v   (lv),
			.left_l   (ll),
			.right_d  (rd),
			.right_v  (rv),
			.right_l  (rl),
			.head_d   (head_dec),
			.tok_in   (ti),
			.fnd_in   (fi),
			.d        (cd[i]),
			.v        (cv[i]),
			.l        (cl[i]),
			.tok      (ctok[i]),
			.fnd      (cfnd[i]),
			.sh       (csh[i])
		);
	end

	logic ins_ok;
	assign ins_ok = (CMP_W'(count_q) < CMP_W'(capacity_q)) &&
	                (CMP_W'(count_q) < CMP_W'(DEPTH));

	always_comb begin
		ctl.by_addr = (kind_q == rprs_pkg::KIND_REMOVE);
		ctl.op      = rprs_pkg::OP_HOLD;
		unique case (state_q)
			ST_EXEC: begin
				unique case (kind_q)
					rprs_pkg::KIND_INSERT: if (ins_ok) ctl.op = rprs_pkg::OP_INSERT;
					rprs_pkg::KIND_CLEAR:  ctl.op = rprs_pkg::OP_CLEAR;
					default:               ctl.op = rprs_pkg::OP_SCAN;
				endcase
			end
			ST_SCAN:    ctl.op = rprs_pkg::OP_SCAN;
			ST_COMPACT: ctl.op = rprs_pkg::OP_COMPACT;
			ST_ROTATE:  if (count_q != '0) ctl.op = rprs_pkg::OP_ROTATE;
			default:    ctl.op = rprs_pkg::OP_HOLD;
		endcase
	end

	logic [CNT_W-1:0] count_ins;
	logic [CNT_W-1:0] count_rem;
	assign count_ins = count_q + CNT_W'(1);
	assign count_rem = csh[DEPTH-1] ? count_q - CNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					step_q <= STP_W'(1);
					unique case (kind_q)
						rprs_pkg::KIND_INSERT: begin
							if (ins_ok)
								count_q <= count_ins;
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
						rprs_pkg::KIND_CLEAR: begin
							count_q     <= '0;
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
						default: state_q <= (DEPTH == 1) ? ST_COMPACT : ST_SCAN;
					endcase
				end
				ST_SCAN: begin
					if (step_q == STP_W'(DEPTH - 1))
						state_q <= ST_COMPACT;
					step_q <= step_q + STP_W'(1);
				end
				ST_COMPACT: begin
					count_q <= count_rem;
					if (kind_q == rprs_pkg::KIND_REMOVE) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_ROTATE;
					end
				end
				ST_ROTATE: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [rprs_pkg::PAY_PORT_W-1:0] head_pay;
	assign head_pay = rprs_pkg::PAY_PORT_W'(cd[0][SW-1:0]);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			addr_q <= s_tdata[15:0];
			new_q  <= {s_tdata[15:0], s_tdata[23:16], bytes_sat, s_tdata[SW+26:27]};
		end
		unique case (state_q)
			ST_EXEC: begin
				if (kind_q == rprs_pkg::KIND_INSERT)
					out_q <= {3'b0, (count_q != '0) || ins_ok, 75'b0, ins_ok};
				else if (kind_q == rprs_pkg::KIND_CLEAR)
					out_q <= {79'b0, 1'b1};
			end
			ST_COMPACT: begin
				out_q <= {3'b0, count_rem != '0, 75'b0, csh[DEPTH-1]};
			end
			ST_ROTATE: begin
				if (count_q != '0)
					out_q <= {3'b0, 1'b1, head_dec[SW+10:SW+3], head_pay,
					          cd[0][SW+2:SW], cd[0][SW+26:SW+11], 1'b1};
				else
					out_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### tb/tb_repeat_packet_ring_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeat packet ring scheduler testbench
// Directed table and random traffic of insert, next, remove and clear with
// random idling on both streams and capacity changes over APB. Every result
// transfer is compared with an in-bench model of the packet ring.
// ----------------------------------------------------------------------------
module tb_repeat_packet_ring_scheduler;

	localparam int NSLOT = 16;
	localparam logic [4:0] NONE = 5'h1f;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [7:0]  rep;
		logic [2:0]  nbytes;
		logic [47:0] pay;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] addr;
		logic [2:0]  cnt;
		logic [47:0] pay;
		logic [7:0]  left;
		logic        more;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [79:0] s_tdata = '0;  // addr, repeat_count, byte_count, payload
	logic [1:0] s_tuser = '0;   // kind
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;       // ok, sent_addr, sent_count, sent_payload,
	                            // repeats_left, has_next
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	repeat_packet_ring_scheduler dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Ring model state.
	logic        r_valid [NSLOT];
	logic [15:0] r_addr [NSLOT];
	logic [7:0]  r_rep [NSLOT];
	logic [2:0]  r_bytes [NSLOT];
	logic [47:0] r_pay [NSLOT];
	logic [4:0]  r_next [NSLOT];
	logic [4:0]  r_prev [NSLOT];
	logic [4:0]  rd_slot, sent_slot;
	int          n_entries;
	logic [4:0]  cap_reg;

	rsp_t expected_rsp[$];
	int   mismatches = 0;
	int   n_rsp = 0;
	int   n_sent = 0;
	bit   stalling = 0;

	function automatic void ring_unlink(logic [4:0] s);
		logic [4:0] p, n;
		p = r_prev[s];
		n = r_next[s];
		if (rd_slot == s) rd_slot = (n == s) ? NONE : n;
		if (sent_slot == s) sent_slot = NONE;
		r_next[p] = n;
		r_prev[n] = p;
		r_valid[s] = 1'b0;
		n_entries--;
	endfunction

	function automatic rsp_t ring_step(req_t q);
		rsp_t o;
		int c;
		int s;
		logic [4:0] e;
		o = '0;
		c = (cap_reg > NSLOT) ? NSLOT : cap_reg;
		case (q.kind)
			rprs_pkg::KIND_INSERT: begin
				s = -1;
				if (n_entries < c)
					for (int i = 0; i < NSLOT; i++)
						if (s < 0 && !r_valid[i]) s = i;
				if (s >= 0) begin
					r_valid[s] = 1'b1;
					r_addr[s] = q.addr;
					r_rep[s] = q.rep;
					r_bytes[s] = (q.nbytes > 6) ? 3'd6 : q.nbytes;
					r_pay[s] = q.pay;
					if (rd_slot == NONE) begin
						r_next[s] = 5'(s);
						r_prev[s] = 5'(s);
					end else begin
						r_next[r_prev[rd_slot]] = 5'(s);
						r_prev[s] = r_prev[rd_slot];
						r_next[s] = rd_slot;
						r_prev[rd_slot] = 5'(s);
					end
					rd_slot = 5'(s);
					n_entries++;
					o.ok = 1'b1;
				end
			end
			rprs_pkg::KIND_NEXT: begin
				if (sent_slot != NONE && r_valid[sent_slot] && r_rep[sent_slot] == 0)
					ring_unlink(sent_slot);
				if (rd_slot != NONE) begin
					e = rd_slot;
					if (r_rep[e] > 0) r_rep[e]--;
					o.addr = r_addr[e];
					o.cnt = r_bytes[e];
					o.pay = r_pay[e];
					o.left = r_rep[e];
					sent_slot = e;
					rd_slot = r_next[e];
					o.ok = 1'b1;
				end
			end
			rprs_pkg::KIND_REMOVE: begin
				e = rd_slot;
				for (int i = 0; i < n_entries && e != NONE && !o.ok; i++) begin
					if (r_addr[e] == q.addr) begin
						ring_unlink(e);
						o.ok = 1'b1;
					end else
						e = r_next[e];
				end
			end
			default: begin
				for (int i = 0; i < NSLOT; i++) r_valid[i] = 1'b0;
				rd_slot = NONE;
				sent_slot = NONE;
				n_entries = 0;
				o.ok = 1'b1;
			end
		endcase
		o.more = (n_entries > 0);
		return o;
	endfunction

	function automatic logic [79:0] pack_rsp(rsp_t o);
		return {3'b0, o.more, o.left, o.pay, o.cnt, o.addr, o.ok};
	endfunction

	// The valid line stays up between back-to-back items and drops only for idle gaps.
	task automatic send_packet(req_t q, bit typed = 0, rsp_t want = '0);
		rsp_t p;
		int   idle;
		idle = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
		if (idle > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		p = ring_step(q);
		if (typed && p != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees with model: %h vs %h", want, p);
		end
		if (q.kind == rprs_pkg::KIND_NEXT && p.ok) n_sent++;
		expected_rsp.push_back(p);
		s_tdata <= {5'b0, q.pay, q.nbytes, q.rep, q.addr};
		s_tuser <= q.kind;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic apb_write(logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_reg = v[4:0];
	endtask

	task automatic settle;
		s_tvalid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	function automatic req_t rand_packet(int addr_span);
		req_t q;
		q.kind = $urandom_range(0, 9) < 4 ? rprs_pkg::KIND_NEXT :
			($urandom_range(0, 5) < 3 ? rprs_pkg::KIND_INSERT :
			($urandom_range(0, 9) == 0 ? rprs_pkg::KIND_CLEAR : rprs_pkg::KIND_REMOVE));
		q.addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, addr_span));
		q.rep = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		q.nbytes = 3'($urandom);
		q.pay = {16'($urandom), 32'($urandom)};
		return q;
	endfunction

	// Result side: random idling, plus one long hold-off to fill the block.
	initial begin
		rsp_t want;
		int   idle;
		@(posedge arst_n);
		forever begin
			if (stalling) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				stalling = 0;
			end
			idle = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
			if (idle > 0) begin
				m_tready <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			n_rsp++;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				want = expected_rsp.pop_front();
				if (pack_rsp(want) !== m_tdata) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ok=%0d addr=%h cnt=%0d pay=%h %s %h",
							want.ok, want.addr, want.cnt, want.pay,
							$sformatf("left=%0d more=%0d, got", want.left, want.more),
							m_tdata);
				end
			end
		end
	end

	initial begin
		#30ms;
		$display("tb: failure");
		$finish;
	end

	req_t tbl_req[$];
	rsp_t tbl_rsp[$];
	bit   tbl_typed[$];

	task automatic row(logic [1:0] k, logic [15:0] a, logic [7:0] r, logic [2:0] b,
			logic [47:0] p, bit t = 0, rsp_t o = '0);
		tbl_req.push_back({k, a, r, b, p});
		tbl_typed.push_back(t);
		tbl_rsp.push_back(o);
	endtask

	initial begin
		rsp_t nil;
		nil = '0;
		cap_reg = rprs_pkg::CAP_RESET;
		n_entries = 0;
		rd_slot = NONE;
		sent_slot = NONE;
		for (int i = 0; i < NSLOT; i++) r_valid[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: next and remove fail.
		row(rprs_pkg::KIND_NEXT, 16'h0, 8'h0, 3'd0, 48'h0, 1, nil);
		row(rprs_pkg::KIND_REMOVE, 16'h1234, 8'h0, 3'd0, 48'h0, 1, nil);
		row(rprs_pkg::KIND_INSERT, 16'hffff, 8'hff, 3'd7, 48'hffff_ffff_ffff,
			1, '{1'b1, 16'h0, 3'd0, 48'h0, 8'h0, 1'b1});
		row(rprs_pkg::KIND_NEXT, 16'h0, 8'h0, 3'd0, 48'h0,
			1, '{1'b1, 16'hffff, 3'd6, 48'hffff_ffff_ffff, 8'hfe, 1'b1});
		row(rprs_pkg::KIND_INSERT, 16'h0000, 8'h0, 3'd0, 48'h0);  // zero repeat count
		row(rprs_pkg::KIND_INSERT, 16'h0005, 8'h1, 3'd6, 48'h0102_0304_0506);
		row(rprs_pkg::KIND_NEXT, 16'h0, 8'h0, 3'd0, 48'h0);
		row(rprs_pkg::KIND_NEXT, 16'h0, 8'h0, 3'd0, 48'h0);
		row(rprs_pkg::KIND_NEXT, 16'h0, 8'h0, 3'd0, 48'h0);
		row(rprs_pkg::KIND_NEXT, 16'h0, 8'h0, 3'd0, 48'h0);
		row(rprs_pkg::KIND_REMOVE, 16'h7777, 8'h0, 3'd0, 48'h0);  // no match
		row(rprs_pkg::KIND_REMOVE, 16'h0005, 8'h0, 3'd0, 48'h0);
		row(rprs_pkg::KIND_NEXT, 16'h0, 8'h0, 3'd0, 48'h0);
		row(rprs_pkg::KIND_REMOVE, 16'hffff, 8'h0, 3'd0, 48'h0);  // last sent packet
		row(rprs_pkg::KIND_NEXT, 16'h0, 8'h0, 3'd0, 48'h0);
		row(rprs_pkg::KIND_CLEAR, 16'h0, 8'h0, 3'd0, 48'h0,
			1, '{1'b1, 16'h0, 3'd0, 48'h0, 8'h0, 1'b0});
		row(rprs_pkg::KIND_NEXT, 16'h0, 8'h0, 3'd0, 48'h0, 1, nil);
		for (int i = 0; i < tbl_req.size(); i++) send_packet(tbl_req[i], tbl_typed[i], tbl_rsp[i]);

		// Random phases across capacity settings, the extremes included.
		for (int ph = 0; ph < 8; ph++) begin
			int capv;
			capv = (ph == 0) ? 31 : (ph == 1) ? 0 : (ph == 2) ? 1 : (ph == 3) ? 16 :
				$urandom_range(1, 17);
			settle();
			apb_write(32'(capv));
			if (ph == 3) stalling = 1;
			for (int i = 0; i < 225; i++) send_packet(rand_packet(ph < 4 ? 7 : 40));
		end

		settle();
		$display("Covered %0d results, %0d packets handed out, capacity 0..31 settings.",
			n_rsp, n_sent);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### sim.f
rtl/core/rprs_pkg.sv
rtl/core/rprs_cell.sv
rtl/core/repeat_packet_ring_scheduler.sv
tb/tb_repeat_packet_ring_scheduler.sv
